// ===== rtl/rcrm_pkg.sv =====
package rcrm_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_U_OFFSET = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_V_OFFSET = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_COS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_COMBINE_MODE = 3'd6;

	localparam logic [1:0] MODE_OVERRIDE = 2'd0;
	localparam logic [1:0] MODE_MAX = 2'd1;
	localparam logic [1:0] MODE_REPLACE = 2'd2;

	localparam logic [0:0] ACTION_LOAD = 1'b0;
	localparam logic [0:0] ACTION_UPDATE = 1'b1;

	localparam logic [7:0] COST_FREE = 8'd0;
	localparam logic [7:0] COST_UNKNOWN = 8'd255;
	localparam logic [7:0] COST_LETHAL = 8'd254;
	localparam logic [7:0] COST_INSCRIBED = 8'd253;

	localparam logic [6:0] OCC_LETHAL = 7'd99;
	localparam logic [6:0] OCC_INSCRIBED = 7'd90;
	localparam logic [14:0] OCC_SCALE = 15'd252;
	localparam logic [14:0] RECIP_89 = 15'd23564;
	localparam int RECIP_SHIFT = 21;

	localparam int PROD_W = 45;
	localparam int SUM_W = 47;
	localparam int FRAC_W = 16;
	localparam int COORD_W = SUM_W - FRAC_W;
	localparam int DIM_W = 9;
	localparam int IDX_W = 2 * DIM_W + 1;

	typedef struct packed {
		logic [0:0] action;
		logic [15:0] load_index;
		logic signed [7:0] raw_occupancy;
		logic [11:0] cell_i;
		logic [11:0] cell_j;
		logic [7:0] prior_cost;
	} item_t;

	typedef struct packed {
		logic [7:0] store_cost;
		logic [0:0] write_cost;
	} result_t;

endpackage

// ===== rtl/rotated_costgrid_resample_merge.sv =====
// Update beat: the result passes through the map, sum, truncate, address, memory read
// and merge steps; item_stall holds until the merge lands in the result register, so
// no new item is taken before an update is through, nor while result_stall holds it.
// Load beat: one per cycle when idle, written straight into the memory, no result.
// Reset clears control state and the configuration registers to their defaults;
// the cost grid memory is not cleared and holds unknown data until loaded.
module rotated_costgrid_resample_merge
	import rcrm_pkg::*;
#(
	parameter int GRID_CELLS = 65536
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL = 3'd1;
	localparam logic [2:0] ST_SUM = 3'd2;
	localparam logic [2:0] ST_POS = 3'd3;
	localparam logic [2:0] ST_ADDR = 3'd4;
	localparam logic [2:0] ST_READ = 3'd5;
	localparam logic [2:0] ST_MERGE = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	logic signed [31:0] u_off_q;
	logic signed [31:0] v_off_q;
	logic signed [31:0] step_cos_q;
	logic signed [31:0] step_sin_q;
	logic [DIM_W-1:0] grid_width_q;
	logic [DIM_W-1:0] grid_height_q;
	logic [1:0] mode_q;
	logic loaded_q;

	logic [7:0] grid_mem [GRID_CELLS];
	logic [7:0] rd_q;

	logic [11:0] cell_i_q;
	logic [11:0] cell_j_q;
	logic [7:0] old_q;
	logic signed [PROD_W-1:0] p_ic_q;
	logic signed [PROD_W-1:0] p_js_q;
	logic signed [PROD_W-1:0] p_is_q;
	logic signed [PROD_W-1:0] p_jc_q;
	logic signed [SUM_W-1:0] u_q;
	logic signed [SUM_W-1:0] v_q;
	logic [DIM_W-1:0] col_q;
	logic [DIM_W-1:0] row_q;
	logic inside_q;
	logic [IDX_W-1:0] idx_q;
	logic hit_q;

	result_t result_q;
	logic result_valid_q;

	logic accept;
	logic load_ok;
	logic [31:0] load_w;
	logic [AW-1:0] load_addr;
	logic [7:0] load_cost;
	logic [14:0] occ_scaled;
	logic [29:0] occ_prod;
	logic [31:0] idx_w;
	logic [AW-1:0] rd_addr;
	logic [COORD_W-1:0] col_tz;
	logic [COORD_W-1:0] row_tz;
	logic col_in;
	logic row_in;
	logic merge_fire;
	result_t merged;

	assign cfg_ready = 1'b1;
	assign item_stall = (state_q != ST_IDLE);
	assign accept = item_valid & ~item_stall;

	assign load_w = 32'(item.load_index);
	assign load_addr = load_w[AW-1:0];
	assign load_ok = accept && (item.action == ACTION_LOAD) && (load_w < 32'(GRID_CELLS));

	assign occ_scaled = 15'(item.raw_occupancy[6:0]) * OCC_SCALE;
	assign occ_prod = 30'(occ_scaled) * 30'(RECIP_89);

	always_comb begin
		if (item.raw_occupancy[7]) begin
			load_cost = COST_UNKNOWN;
		end else if (item.raw_occupancy[6:0] == 7'd0) begin
			load_cost = COST_FREE;
		end else if (item.raw_occupancy[6:0] >= OCC_LETHAL) begin
			load_cost = COST_LETHAL;
		end else if (item.raw_occupancy[6:0] >= OCC_INSCRIBED) begin
			load_cost = COST_INSCRIBED;
		end else begin
			load_cost = 8'd1 + 8'(occ_prod >> RECIP_SHIFT);
		end
	end

	assign idx_w = 32'(idx_q);
	assign rd_addr = idx_w[AW-1:0];

	always_ff @(posedge clk) begin
		if (load_ok) begin
			grid_mem[load_addr] <= load_cost;
		end
		if (state_q == ST_READ) begin
			rd_q <= grid_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_off_q <= '0;
			v_off_q <= '0;
			step_cos_q <= 32'sd65536;
			step_sin_q <= '0;
			grid_width_q <= 9'd256;
			grid_height_q <= 9'd256;
			mode_q <= MODE_OVERRIDE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_U_OFFSET: u_off_q <= cfg_data;
				CFG_V_OFFSET: v_off_q <= cfg_data;
				CFG_STEP_COS: step_cos_q <= cfg_data;
				CFG_STEP_SIN: step_sin_q <= cfg_data;
				CFG_GRID_WIDTH: grid_width_q <= cfg_data[DIM_W-1:0];
				CFG_GRID_HEIGHT: grid_height_q <= cfg_data[DIM_W-1:0];
				CFG_COMBINE_MODE: mode_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		col_tz = u_q[SUM_W-1:FRAC_W] +
			COORD_W'(u_q[SUM_W-1] && (u_q[FRAC_W-1:0] != '0));
		row_tz = v_q[SUM_W-1:FRAC_W] +
			COORD_W'(v_q[SUM_W-1] && (v_q[FRAC_W-1:0] != '0));
		col_in = !col_tz[COORD_W-1] && (col_tz < COORD_W'(grid_width_q));
		row_in = !row_tz[COORD_W-1] && (row_tz < COORD_W'(grid_height_q));
	end

	always_ff @(posedge clk) begin
		if (accept && (item.action == ACTION_UPDATE)) begin
			cell_i_q <= item.cell_i;
			cell_j_q <= item.cell_j;
			old_q <= item.prior_cost;
		end
		if (state_q == ST_MUL) begin
			p_ic_q <= $signed({1'b0, cell_i_q}) * step_cos_q;
			p_js_q <= $signed({1'b0, cell_j_q}) * step_sin_q;
			p_is_q <= $signed({1'b0, cell_i_q}) * step_sin_q;
			p_jc_q <= $signed({1'b0, cell_j_q}) * step_cos_q;
		end
		if (state_q == ST_SUM) begin
			u_q <= SUM_W'(u_off_q) + SUM_W'(p_ic_q) + SUM_W'(p_js_q);
			v_q <= SUM_W'(v_off_q) - SUM_W'(p_is_q) + SUM_W'(p_jc_q);
		end
		if (state_q == ST_POS) begin
			col_q <= col_tz[DIM_W-1:0];
			row_q <= row_tz[DIM_W-1:0];
			inside_q <= col_in & row_in;
		end
		if (state_q == ST_ADDR) begin
			idx_q <= IDX_W'(18'(row_q) * 18'(grid_width_q)) + IDX_W'(col_q);
		end
		if (state_q == ST_READ) begin
			hit_q <= inside_q & loaded_q & (idx_w < 32'(GRID_CELLS));
		end
	end

	always_comb begin
		merged.store_cost = old_q;
		merged.write_cost = 1'b0;
		if (hit_q) begin
			if (mode_q == MODE_OVERRIDE) begin
				merged.store_cost = rd_q;
				merged.write_cost = 1'b1;
			end else if (!(rd_q == COST_UNKNOWN && old_q != COST_UNKNOWN)) begin
				if (mode_q == MODE_MAX) begin
					merged.store_cost = (old_q == COST_UNKNOWN) ? rd_q :
						((old_q > rd_q) ? old_q : rd_q);
				end else begin
					merged.store_cost = rd_q;
				end
				merged.write_cost = 1'b1;
			end
		end
	end

	assign merge_fire = (state_q == ST_MERGE) && (!result_valid_q || !result_stall);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (accept && (item.action == ACTION_UPDATE)) state_nxt = ST_MUL;
			ST_MUL: state_nxt = ST_SUM;
			ST_SUM: state_nxt = ST_POS;
			ST_POS: state_nxt = ST_ADDR;
			ST_ADDR: state_nxt = ST_READ;
			ST_READ: state_nxt = ST_MERGE;
			ST_MERGE: if (merge_fire) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			loaded_q <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (load_ok) begin
				loaded_q <= 1'b1;
			end
			if (merge_fire) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (merge_fire) begin
			result_q <= merged;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule

// ===== rtl/rcrm_checker.sv =====
module rcrm_checker
	import rcrm_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_stall,
	input item_t   item,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	logic item_beat;

	assign item_beat = item_valid & ~item_stall;

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_beat && (item.action == ACTION_LOAD) && !result_valid |=> !result_valid)
		else $error("load beat produced a result");

	a_update_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_beat && (item.action == ACTION_UPDATE) |=> item_stall)
		else $error("input not stalled while update in flight");

	a_update_not_instant: assert property (@(posedge clk) disable iff (!arst_n)
		item_beat && (item.action == ACTION_UPDATE) && !result_valid |=> !result_valid)
		else $error("update result appeared too early");

endmodule

bind rotated_costgrid_resample_merge rcrm_checker u_rcrm_checker (.*);

// ===== tb/rotated_costgrid_resample_merge_tb.sv =====
module rotated_costgrid_resample_merge_tb
	import rcrm_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] MODE_UNSELECTED = 2'd3;
	localparam int OCC_SPAN = 89;
	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_CYCLES = 200;
	localparam int GRID_CELLS = 65536;
	localparam int unsigned CYCLE_LIMIT = 300000;

	logic clk = 1'b0;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	item_t item;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	logic signed [31:0] cfg_u_offset;
	logic signed [31:0] cfg_v_offset;
	logic signed [31:0] cfg_step_cos;
	logic signed [31:0] cfg_step_sin;
	logic [8:0] cfg_grid_width;
	logic [8:0] cfg_grid_height;
	logic [1:0] cfg_mode;

	logic [7:0] sensor_costs [GRID_CELLS];
	bit sensor_written [GRID_CELLS];
	bit any_load = 1'b0;
	result_t pending_costs [$];

	int errors = 0;
	bit gaps_on = 1'b1;
	bit hold_armed = 1'b0;
	int hold_count = 0;
	int sink_wait = 0;
	int unsigned cycle_count = 0;

	rotated_costgrid_resample_merge u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [7:0] occupancy_cost(logic signed [7:0] raw);
		int v;
		v = raw;
		if (v < 0) return COST_UNKNOWN;
		if (v == 0) return COST_FREE;
		if (v >= int'(OCC_LETHAL)) return COST_LETHAL;
		if (v >= int'(OCC_INSCRIBED)) return COST_INSCRIBED;
		return 8'(1 + v * int'(OCC_SCALE) / OCC_SPAN);
	endfunction

	function automatic bit map_to_sensor(logic [11:0] ci, logic [11:0] cj,
			output int unsigned idx);
		longint c, s, u, v, col, row;
		bit hit;
		c = longint'(cfg_step_cos);
		s = longint'(cfg_step_sin);
		u = longint'(cfg_u_offset) + longint'(ci) * c + longint'(cj) * s;
		v = longint'(cfg_v_offset) - longint'(ci) * s + longint'(cj) * c;
		col = u / 65536;
		row = v / 65536;
		hit = col >= 0 && col < longint'(cfg_grid_width) &&
			row >= 0 && row < longint'(cfg_grid_height);
		hit = hit && (row * longint'(cfg_grid_width) + col < longint'(GRID_CELLS));
		idx = hit ? 32'(row * longint'(cfg_grid_width) + col) : 0;
		return hit;
	endfunction

	function automatic result_t predict_merge(item_t it);
		result_t r;
		int unsigned idx;
		logic [7:0] sc;
		r.store_cost = it.prior_cost;
		r.write_cost = 1'b0;
		if (any_load && map_to_sensor(it.cell_i, it.cell_j, idx)) begin
			sc = sensor_costs[idx];
			if (cfg_mode == MODE_OVERRIDE) begin
				r.store_cost = sc;
				r.write_cost = 1'b1;
			end else if (!(sc == COST_UNKNOWN && it.prior_cost != COST_UNKNOWN)) begin
				if (cfg_mode == MODE_MAX)
					r.store_cost = (it.prior_cost == COST_UNKNOWN || sc > it.prior_cost) ?
						sc : it.prior_cost;
				else
					r.store_cost = sc;
				r.write_cost = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic void flag_error(string msg);
		errors++;
		if (errors <= 10)
			$display("%0t: %s", $time, msg);
	endfunction

	function automatic item_t random_item();
		logic [63:0] bits;
		bits = {$urandom, $urandom};
		return bits[$bits(item_t)-1:0];
	endfunction

	task automatic send_item(item_t it);
		int gap;
		gap = gaps_on ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		if (it.action == ACTION_LOAD) begin
			sensor_costs[it.load_index] = occupancy_cost(it.raw_occupancy);
			sensor_written[it.load_index] = 1'b1;
			any_load = 1'b1;
		end else
			pending_costs.insert(pending_costs.size(), predict_merge(it));
	endtask

	task automatic send_load(logic [15:0] idx, logic [7:0] raw);
		item_t it;
		it = random_item();
		it.action = ACTION_LOAD;
		it.load_index = idx;
		it.raw_occupancy = raw;
		send_item(it);
	endtask

	task automatic send_update(logic [11:0] ci, logic [11:0] cj, logic [7:0] old);
		item_t it;
		int unsigned idx;
		// load the target first so no sensor cell is read before it is written
		if (any_load && map_to_sensor(ci, cj, idx) && !sensor_written[idx])
			send_load(16'(idx), 8'($urandom_range(0, 101) - 1));
		it = random_item();
		it.action = ACTION_UPDATE;
		it.cell_i = ci;
		it.cell_j = cj;
		it.prior_cost = old;
		send_item(it);
	endtask

	task automatic wait_results_idle();
		item_valid <= 1'b0;
		while (pending_costs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (index)
			CFG_U_OFFSET: cfg_u_offset = data;
			CFG_V_OFFSET: cfg_v_offset = data;
			CFG_STEP_COS: cfg_step_cos = data;
			CFG_STEP_SIN: cfg_step_sin = data;
			CFG_GRID_WIDTH: cfg_grid_width = data[8:0];
			CFG_GRID_HEIGHT: cfg_grid_height = data[8:0];
			CFG_COMBINE_MODE: cfg_mode = data[1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic apply_setting(logic [31:0] uo, logic [31:0] vo, logic [31:0] c,
			logic [31:0] s, logic [31:0] w, logic [31:0] h, logic [1:0] md);
		write_reg(CFG_U_OFFSET, uo);
		write_reg(CFG_V_OFFSET, vo);
		write_reg(CFG_STEP_COS, c);
		write_reg(CFG_STEP_SIN, s);
		write_reg(CFG_GRID_WIDTH, w);
		write_reg(CFG_GRID_HEIGHT, h);
		write_reg(CFG_COMBINE_MODE, 32'(md));
	endtask

	task automatic test_cost_conversion();
		logic [7:0] probes [11];
		probes = '{8'hFF, 8'd0, 8'd1, 8'd88, 8'd89, 8'd90, 8'd98, 8'd99, 8'd100, 8'd127,
			8'h80};
		send_update(12'd3, 12'd0, 8'd77);
		for (int k = 0; k < 11; k++)
			send_load(16'(k), probes[k]);
		for (int k = 0; k < 11; k++)
			send_update(12'(k), 12'd0, (k % 2 == 1) ? COST_UNKNOWN : 8'(k * 20));
		send_load(16'hFFFF, 8'd50);
		send_update(12'd255, 12'd255, 8'd1);
		send_update(12'hFFF, 12'hFFF, 8'd9);
		wait_results_idle();
	endtask

	task automatic test_merge_modes();
		logic [1:0] md;
		for (int n = 0; n < 3; n++) begin
			md = (n == 0) ? MODE_MAX : (n == 1) ? MODE_REPLACE : MODE_UNSELECTED;
			write_reg(CFG_COMBINE_MODE, 32'(md));
			send_update(12'd0, 12'd0, 8'd5);
			send_update(12'd0, 12'd0, COST_UNKNOWN);
			send_update(12'd5, 12'd0, COST_LETHAL);
			send_update(12'd1, 12'd0, COST_UNKNOWN);
			wait_results_idle();
		end
	endtask

	task automatic test_mapping();
		// half-cell negative offsets must truncate toward zero into cell zero
		apply_setting(32'hFFFF_8000, 32'hFFFF_8000, 32'h0001_0000, 32'd0, 32'd16, 32'd16,
			MODE_OVERRIDE);
		send_update(12'd0, 12'd0, 8'd11);
		send_update(12'd10, 12'd1, 8'd12);
		send_update(12'd16, 12'd0, 8'd13);
		send_update(12'd17, 12'd3, 8'd14);
		send_update(12'd3, 12'd17, 8'd15);
		wait_results_idle();
		apply_setting(32'h000F_0000, 32'd0, 32'd0, 32'hFFFF_0000, 32'd16, 32'd16,
			MODE_REPLACE);
		send_update(12'd2, 12'd0, 8'd21);
		send_update(12'd0, 12'd15, 8'd22);
		send_update(12'd0, 12'd16, 8'd23);
		wait_results_idle();
	endtask

	task automatic test_random_traffic();
		logic [31:0] uo, vo, c, s;
		int w, h, span;
		logic [1:0] md;
		logic [11:0] ci, cj;
		logic [7:0] old, raw;
		for (int ph = 0; ph < 10; ph++) begin
			w = ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(1, 256);
			h = ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(1, 256);
			c = 32'($urandom_range(0, 131072)) - 32'd65536;
			s = 32'($urandom_range(0, 131072)) - 32'd65536;
			uo = 32'($urandom_range(0, w * 65536));
			vo = 32'($urandom_range(0, h * 65536));
			md = 2'($urandom_range(0, 3));
			span = 40;
			case (ph)
				0: begin
					uo = 32'h7FFF_FFFF;
					vo = 32'h8000_0000;
					c = 32'h7FFF_FFFF;
					s = 32'h8000_0000;
				end
				1: begin
					uo = 32'h8000_0000;
					vo = 32'hFFFF_FFFF;
					c = 32'h8000_0000;
					s = 32'h7FFF_FFFF;
					w = 1;
					h = 1;
				end
				2: begin
					uo = 32'd0;
					vo = 32'd0;
					c = 32'h0001_0000;
					s = 32'd0;
					w = 256;
					h = 256;
					span = 300;
				end
				3: begin
					w = 1;
					h = 256;
				end
				default: ;
			endcase
			apply_setting(uo, vo, c, s, 32'(w), 32'(h), md);
			gaps_on = (ph % 4 != 3);
			repeat (25) begin
				if ($urandom_range(0, 99) < 35) begin
					raw = ($urandom_range(0, 5) == 0) ? 8'($urandom) :
						8'($urandom_range(0, 101) - 1);
					if ($urandom_range(0, 9) < 7)
						send_load(16'($urandom_range(0, h - 1) * w + $urandom_range(0, w - 1)),
							raw);
					else
						send_load(16'($urandom), raw);
				end else begin
					ci = ($urandom_range(0, 6) == 0) ? 12'($urandom) : 12'($urandom_range(0, span));
					cj = ($urandom_range(0, 6) == 0) ? 12'($urandom) : 12'($urandom_range(0, span));
					old = ($urandom_range(0, 3) == 0) ? COST_UNKNOWN : 8'($urandom);
					send_update(ci, cj, old);
				end
			end
			wait_results_idle();
		end
		gaps_on = 1'b1;
	endtask

	task automatic test_backpressure();
		apply_setting(32'd0, 32'd0, 32'h0001_0000, 32'd0, 32'd256, 32'd256, MODE_MAX);
		gaps_on = 1'b0;
		hold_armed = 1'b1;
		repeat (40)
			send_update(12'($urandom_range(0, 255)), 12'($urandom_range(0, 255)), 8'($urandom));
		wait_results_idle();
		gaps_on = 1'b1;
		repeat (20)
			send_update(12'($urandom_range(0, 255)), 12'($urandom_range(0, 255)), 8'($urandom));
		wait_results_idle();
	endtask

	always @(posedge clk) begin : result_sink
		int w;
		if (hold_armed && hold_count < HOLD_CYCLES) begin
			result_stall <= 1'b1;
			hold_count <= hold_count + 1;
		end else if (result_valid && !result_stall) begin
			w = gaps_on ? $urandom_range(0, 7) : 0;
			sink_wait <= w;
			result_stall <= (w != 0);
		end else if (sink_wait > 0) begin
			result_stall <= (sink_wait > 1);
			sink_wait <= sink_wait - 1;
		end else
			result_stall <= 1'b0;
	end

	always @(posedge clk) begin : result_monitor
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_costs.size() == 0)
				flag_error($sformatf("unexpected beat: store_cost %0d write_cost %0d",
					result.store_cost, result.write_cost));
			else begin
				want = pending_costs.pop_front();
				if (result.store_cost !== want.store_cost)
					flag_error($sformatf("store_cost expected %0d got %0d",
						want.store_cost, result.store_cost));
				if (result.write_cost !== want.write_cost)
					flag_error($sformatf("write_cost expected %0d got %0d",
						want.write_cost, result.write_cost));
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		cfg_u_offset = 32'd0;
		cfg_v_offset = 32'd0;
		cfg_step_cos = 32'h0001_0000;
		cfg_step_sin = 32'd0;
		cfg_grid_width = 9'd256;
		cfg_grid_height = 9'd256;
		cfg_mode = MODE_OVERRIDE;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_cost_conversion();
		test_merge_modes();
		test_mapping();
		test_random_traffic();
		test_backpressure();
		wait_results_idle();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
